[src/ddo_pkg.sv]
package ddo_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int ANGLE_UP = 32 - ANGLE_BITS;
	localparam int HEAD_S = 64 - ANGLE_BITS;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [63:0] RAD_TO_TURN = 64'sd683565276;

	localparam logic [2:0] REG_STEP_TIME = 3'd0;
	localparam logic [2:0] REG_WHEEL_RADIUS = 3'd1;
	localparam logic [2:0] REG_INV_WHEEL_RADIUS = 3'd2;
	localparam logic [2:0] REG_HALF_SEPARATION = 3'd3;
	localparam logic [2:0] REG_INV_SEPARATION = 3'd4;
	localparam logic [2:0] REG_INV_STEP_TIME = 3'd5;

	localparam logic [3:0] OP_TR = 4'd0;
	localparam logic [3:0] OP_DL = 4'd1;
	localparam logic [3:0] OP_DD = 4'd2;
	localparam logic [3:0] OP_DA = 4'd3;
	localparam logic [3:0] OP_PX = 4'd4;
	localparam logic [3:0] OP_PY = 4'd5;
	localparam logic [3:0] OP_HLO = 4'd6;
	localparam logic [3:0] OP_HHI = 4'd7;
	localparam logic [3:0] OP_ANGV = 4'd8;
	localparam logic [3:0] OP_LINV = 4'd9;
	localparam logic [3:0] OP_TW = 4'd10;
	localparam logic [3:0] OP_LEFT = 4'd11;
	localparam logic [3:0] OP_RIGHT = 4'd12;

	typedef struct packed {
		logic start;
		logic signed [63:0] a;
		logic signed [33:0] b;
		logic [5:0] n;
	} mul_req_t;

	function automatic logic signed [31:0] atan_turns(input logic [3:0] i);
		logic signed [31:0] r;
		unique case (i)
			4'd0: r = 32'sd536870912;
			4'd1: r = 32'sd316933406;
			4'd2: r = 32'sd167458907;
			4'd3: r = 32'sd85004756;
			4'd4: r = 32'sd42667331;
			4'd5: r = 32'sd21354465;
			4'd6: r = 32'sd10679838;
			4'd7: r = 32'sd5340245;
			4'd8: r = 32'sd2670163;
			4'd9: r = 32'sd1335087;
			4'd10: r = 32'sd667544;
			4'd11: r = 32'sd333772;
			4'd12: r = 32'sd166886;
			4'd13: r = 32'sd83443;
			4'd14: r = 32'sd41722;
			default: r = 32'sd20861;
		endcase
		return r;
	endfunction

	function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
		input int unsigned sh);
		return (v + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
		logic signed [23:0] r;
		if (v > 64'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -64'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

[src/ddo_in_if.sv]
interface ddo_in_if;
	logic valid;
	logic ready;
	logic signed [23:0] left_wheel_vel;
	logic signed [23:0] right_wheel_vel;
	logic signed [23:0] cmd_linear_vel;
	logic signed [23:0] cmd_angular_vel;
	modport source(output valid, left_wheel_vel, right_wheel_vel, cmd_linear_vel,
		cmd_angular_vel, input ready);
	modport sink(input valid, left_wheel_vel, right_wheel_vel, cmd_linear_vel,
		cmd_angular_vel, output ready);
endinterface

[src/ddo_out_if.sv]
interface ddo_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] pose_x_out;
	logic signed [31:0] pose_y_out;
	logic [15:0] heading_out;
	logic signed [23:0] odom_linear_vel;
	logic signed [23:0] odom_angular_vel;
	logic signed [23:0] left_drive_vel;
	logic signed [23:0] right_drive_vel;
	modport source(output valid, pose_x_out, pose_y_out, heading_out, odom_linear_vel,
		odom_angular_vel, left_drive_vel, right_drive_vel, input ready);
	modport sink(input valid, pose_x_out, pose_y_out, heading_out, odom_linear_vel,
		odom_angular_vel, left_drive_vel, right_drive_vel, output ready);
endinterface

[src/ddo_cfg_if.sv]
interface ddo_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [23:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[src/ddo_mul.sv]
module ddo_mul (
	input logic clk,
	input logic arst_n,
	input ddo_pkg::mul_req_t req,
	output logic signed [63:0] prod,
	output logic done
);

	logic signed [63:0] acc_q;
	logic signed [63:0] a_q;
	logic signed [33:0] b_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= req.n;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// The top bit of the multiplier carries negative weight.
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q <= req.a;
			b_q <= req.b;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= (cnt_q == 6'd1) ? acc_q - a_q : acc_q + a_q;
			end
			a_q <= a_q <<< 1;
			b_q <= b_q >>> 1;
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

[src/ddo_cordic.sv]
module ddo_cordic (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] ang,
	output logic signed [33:0] cs,
	output logic signed [33:0] sn
);

	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic signed [31:0] z_q;
	logic [3:0] i_q;
	logic busy_q;
	logic flip_q;
	logic flip;
	logic [31:0] ang_r;
	logic signed [33:0] dx;
	logic signed [33:0] dy;
	logic signed [31:0] at;

	always_comb begin
		flip = (ang > 32'h40000000) && (ang < 32'hC0000000);
		ang_r = flip ? ang + 32'h80000000 : ang;
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		at = ddo_pkg::atan_turns(i_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q <= '0;
		end else if (busy_q) begin
			i_q <= i_q + 4'd1;
			if (i_q == 4'd15) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= ddo_pkg::CORDIC_GAIN;
			y_q <= '0;
			z_q <= $signed(ang_r);
			flip_q <= flip;
		end else if (busy_q) begin
			if (!z_q[31]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign cs = flip_q ? -x_q : x_q;
	assign sn = flip_q ? -y_q : y_q;

endmodule

[src/diff_drive_odometry_step_core.sv]
// Differential-drive odometry step.
// inp takes one request per control tick: measured wheel rates and the
// commanded linear and angular velocity. res returns one result per request:
// the updated pose, the odometric velocities and the two wheel commands.
// cfg writes the six geometry and timing registers; it is always ready. The
// user must see that it is written only while no request is in flight; the
// block itself does not enforce this. The bit-serial multiplier runs
// thirteen products one multiplier bit per cycle; the sine/cosine unit
// iterates alongside the first products.
// One request is worked on at a time; inp is ready only when idle.
// A finished result sits in the output register until res takes it. If the
// previous result is still waiting, the next one holds until it is taken.
// Reset clears pose and heading to zero and loads the default registers.
module diff_drive_odometry_step_core (
	input logic clk,
	input logic arst_n,
	ddo_in_if.sink inp,
	ddo_out_if.source res,
	ddo_cfg_if.sink cfg
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;
	localparam int AB = ddo_pkg::ANGLE_BITS;

	logic [1:0] state_q;
	logic [3:0] op_q;
	logic [23:0] st_q;
	logic [15:0] rad_q;
	logic [15:0] irad_q;
	logic [15:0] hsep_q;
	logic [15:0] isep_q;
	logic [15:0] ist_q;
	logic signed [23:0] wl_q;
	logic signed [23:0] wr_q;
	logic signed [23:0] vl_q;
	logic signed [23:0] va_q;
	logic [39:0] tr_q;
	logic signed [31:0] dl_q;
	logic signed [31:0] dd_q;
	logic signed [48:0] da_q;
	logic signed [47:0] lo_q;
	logic signed [24:0] tw_q;
	logic signed [31:0] pose_x_q;
	logic signed [31:0] pose_y_q;
	logic [AB-1:0] heading_q;
	logic signed [23:0] angv_q;
	logic signed [23:0] linv_q;
	logic signed [23:0] left_q;
	logic signed [23:0] right_q;
	logic out_valid_q;

	ddo_pkg::mul_req_t mreq;
	logic signed [63:0] prod;
	logic mdone;
	logic signed [33:0] cs;
	logic signed [33:0] sn;
	logic accept;
	logic [31:0] ang;
	logic signed [32:0] dsum;
	logic signed [32:0] ddiff;
	logic signed [31:0] dr;
	logic signed [25:0] lsum;
	logic signed [25:0] rdiff;
	logic signed [63:0] hlo;
	logic signed [63:0] hacc;
	logic signed [63:0] delta;
	logic [39:0] hx;
	logic out_load;

	assign accept = inp.valid && inp.ready;
	assign inp.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign ang = 32'(heading_q) << ddo_pkg::ANGLE_UP;

	ddo_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mreq),
		.prod(prod),
		.done(mdone)
	);

	ddo_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept),
		.ang(ang),
		.cs(cs),
		.sn(sn)
	);

	always_comb begin
		dsum = dl_q + dd_q;
		ddiff = dl_q - dd_q;
		dr = dsum[32:1];
		lsum = vl_q + tw_q;
		rdiff = vl_q - tw_q;
		hlo = (prod + (64'sd1 <<< (ddo_pkg::HEAD_S - 1))) >>> 16;
		hacc = prod + 64'(lo_q);
		delta = hacc >>> (ddo_pkg::HEAD_S - 16);
		hx = 40'(heading_q) << 16;
		out_load = (state_q == ST_DONE) && (!out_valid_q || res.ready);
	end

	always_comb begin
		mreq.start = (state_q == ST_LOAD);
		mreq.a = '0;
		mreq.b = '0;
		mreq.n = 6'd17;
		unique case (op_q)
			ddo_pkg::OP_TR: begin
				mreq.a = 64'(st_q);
				mreq.b = 34'(rad_q);
			end
			ddo_pkg::OP_DL: begin
				mreq.a = 64'(tr_q);
				mreq.b = 34'(wl_q);
				mreq.n = 6'd24;
			end
			ddo_pkg::OP_DD: begin
				mreq.a = 64'(tr_q);
				mreq.b = 34'(wr_q);
				mreq.n = 6'd24;
			end
			ddo_pkg::OP_DA: begin
				mreq.a = 64'(ddiff);
				mreq.b = 34'(isep_q);
			end
			ddo_pkg::OP_PX: begin
				mreq.a = 64'(dr);
				mreq.b = cs;
				mreq.n = 6'd34;
			end
			ddo_pkg::OP_PY: begin
				mreq.a = 64'(dr);
				mreq.b = sn;
				mreq.n = 6'd34;
			end
			ddo_pkg::OP_HLO: begin
				mreq.a = ddo_pkg::RAD_TO_TURN;
				mreq.b = 34'(da_q[15:0]);
			end
			ddo_pkg::OP_HHI: begin
				mreq.a = ddo_pkg::RAD_TO_TURN;
				mreq.b = 34'($signed(da_q[48:16]));
				mreq.n = 6'd34;
			end
			ddo_pkg::OP_ANGV: begin
				mreq.a = 64'(da_q);
				mreq.b = 34'(ist_q);
			end
			ddo_pkg::OP_LINV: begin
				mreq.a = 64'(dr);
				mreq.b = 34'(ist_q);
			end
			ddo_pkg::OP_TW: begin
				mreq.a = 64'(va_q);
				mreq.b = 34'(hsep_q);
			end
			ddo_pkg::OP_LEFT: begin
				mreq.a = 64'(lsum);
				mreq.b = 34'(irad_q);
			end
			ddo_pkg::OP_RIGHT: begin
				mreq.a = 64'(rdiff);
				mreq.b = 34'(irad_q);
			end
			default: begin
				mreq.a = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= ddo_pkg::OP_TR;
			out_valid_q <= 1'b0;
			st_q <= 24'd16777;
			rad_q <= 16'd4915;
			irad_q <= 16'd3413;
			hsep_q <= 16'd11141;
			isep_q <= 16'd753;
			ist_q <= 16'd1000;
			pose_x_q <= '0;
			pose_y_q <= '0;
			heading_q <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					ddo_pkg::REG_STEP_TIME: st_q <= cfg.data;
					ddo_pkg::REG_WHEEL_RADIUS: rad_q <= cfg.data[15:0];
					ddo_pkg::REG_INV_WHEEL_RADIUS: irad_q <= cfg.data[15:0];
					ddo_pkg::REG_HALF_SEPARATION: hsep_q <= cfg.data[15:0];
					ddo_pkg::REG_INV_SEPARATION: isep_q <= cfg.data[15:0];
					ddo_pkg::REG_INV_STEP_TIME: ist_q <= cfg.data[15:0];
					default: begin
					end
				endcase
			end
			if (out_valid_q && res.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q <= ddo_pkg::OP_TR;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (mdone) begin
						if (op_q == ddo_pkg::OP_PX) begin
							pose_x_q <= ddo_pkg::sat32(64'(pose_x_q) + ddo_pkg::rnd(prod, 38));
						end
						if (op_q == ddo_pkg::OP_PY) begin
							pose_y_q <= ddo_pkg::sat32(64'(pose_y_q) + ddo_pkg::rnd(prod, 38));
						end
						if (op_q == ddo_pkg::OP_HHI) begin
							heading_q <= heading_q + delta[AB-1:0];
						end
						if (op_q == ddo_pkg::OP_RIGHT) begin
							state_q <= ST_DONE;
						end else begin
							op_q <= op_q + 4'd1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wl_q <= inp.left_wheel_vel;
			wr_q <= inp.right_wheel_vel;
			vl_q <= inp.cmd_linear_vel;
			va_q <= inp.cmd_angular_vel;
		end
		if (state_q == ST_WAIT && mdone) begin
			unique case (op_q)
				ddo_pkg::OP_TR: tr_q <= prod[39:0];
				ddo_pkg::OP_DL: dl_q <= 32'(ddo_pkg::rnd(prod, 32));
				ddo_pkg::OP_DD: dd_q <= 32'(ddo_pkg::rnd(prod, 32));
				ddo_pkg::OP_DA: da_q <= prod[48:0];
				ddo_pkg::OP_HLO: lo_q <= 48'(hlo);
				ddo_pkg::OP_ANGV: begin
					if (ist_q == 16'd0) begin
						angv_q <= '0;
					end else if (64'(da_q) >= 64'sd70368744177664) begin
						angv_q <= 24'sh7FFFFF;
					end else if (64'(da_q) <= -64'sd70368744177664) begin
						angv_q <= 24'sh800000;
					end else begin
						angv_q <= ddo_pkg::sat24(ddo_pkg::rnd(prod, 16));
					end
				end
				ddo_pkg::OP_LINV: linv_q <= ddo_pkg::sat24(ddo_pkg::rnd(prod, 8));
				ddo_pkg::OP_TW: tw_q <= 25'(ddo_pkg::rnd(prod, 16));
				ddo_pkg::OP_LEFT: left_q <= ddo_pkg::sat24(ddo_pkg::rnd(prod, 8));
				ddo_pkg::OP_RIGHT: right_q <= ddo_pkg::sat24(ddo_pkg::rnd(prod, 8));
				default: begin
				end
			endcase
		end
		if (out_load) begin
			res.pose_x_out <= pose_x_q;
			res.pose_y_out <= pose_y_q;
			res.heading_out <= hx[AB +: 16];
			res.odom_linear_vel <= linv_q;
			res.odom_angular_vel <= angv_q;
			res.left_drive_vel <= left_q;
			res.right_drive_vel <= right_q;
		end
	end

	assign res.valid = out_valid_q;

endmodule
